// File: design/pcm_pkg.sv
// Shared types, widths and orientation constants for the phase congruency moment block.
package pcm_pkg;

    // Input sample format: unsigned, all bits fractional.
    localparam int PC_W    = 16;
    localparam int PC_FRAC = 16;
    localparam int N_IN    = 6;

    // Trig constants: magnitude in Q1.15, one is 2^15.
    localparam int TRIG_W    = 16;
    localparam int TRIG_FRAC = 15;

    // Covariance terms stay below 2^17 in magnitude for any orientation count.
    localparam int COV_W  = 18;
    localparam int SUM_W  = COV_W + 1;
    localparam int ROOT_W = COV_W;
    localparam int SQ_W   = 2 * ROOT_W;
    localparam int MOM_W  = SUM_W + 1;

    // Output byte and its scale factor.
    localparam int          OUT_W      = 8;
    localparam logic [7:0]  BYTE_MAX   = 8'd255;
    localparam logic [15:0] EPS_RESET  = 16'd7;

    // Pipeline control that travels with a stage group.
    typedef struct packed {
        logic adv;
        logic vld;
    } pipe_ctl_t;

    // Rounded Q1.15 magnitude of cos(k*pi/n) for 0 <= k <= n/2.
    function automatic int cos_mag(input int n, input int k);
        int v;
        v = 0;
        if (k == 0)
        begin
            v = 32768;
        end
        else if (2 * k == n)
        begin
            v = 0;
        end
        else
        begin
            case (n * 16 + k)
                3 * 16 + 1: v = 16384;
                4 * 16 + 1: v = 23170;
                5 * 16 + 1: v = 26510;
                5 * 16 + 2: v = 10126;
                6 * 16 + 1: v = 28378;
                6 * 16 + 2: v = 16384;
                7 * 16 + 1: v = 29523;
                7 * 16 + 2: v = 20431;
                7 * 16 + 3: v = 7292;
                8 * 16 + 1: v = 30274;
                8 * 16 + 2: v = 23170;
                8 * 16 + 3: v = 12540;
                default:    v = 0;
            endcase
        end
        return v;
    endfunction

    // Rounded Q1.15 magnitude of sin(k*pi/n) for 0 <= k <= n/2.
    function automatic int sin_mag(input int n, input int k);
        int v;
        v = 0;
        if (k == 0)
        begin
            v = 0;
        end
        else if (2 * k == n)
        begin
            v = 32768;
        end
        else
        begin
            case (n * 16 + k)
                3 * 16 + 1: v = 28378;
                4 * 16 + 1: v = 23170;
                5 * 16 + 1: v = 19261;
                5 * 16 + 2: v = 31164;
                6 * 16 + 1: v = 16384;
                6 * 16 + 2: v = 28378;
                7 * 16 + 1: v = 14218;
                7 * 16 + 2: v = 25619;
                7 * 16 + 3: v = 31946;
                8 * 16 + 1: v = 12540;
                8 * 16 + 2: v = 23170;
                8 * 16 + 3: v = 30274;
                default:    v = 0;
            endcase
        end
        return v;
    endfunction

    // Signed Q1.15 cos or sin of o*pi/n; past pi/2 the cosine changes sign.
    function automatic int trig_q15(input int n, input int o, input bit want_sin);
        int  k;
        bit  flip;
        int  m;
        k    = (2 * o > n) ? (n - o) : o;
        flip = (2 * o > n) && !want_sin;
        m    = want_sin ? sin_mag(n, k) : cos_mag(n, k);
        return flip ? -m : m;
    endfunction

endpackage

// File: design/pcm_lane.sv
// One orientation lane: projects the sample onto cos and sin and forms the three products.
module pcm_lane
    import pcm_pkg::*;
#(
    parameter int NUM_ORIENT = 6,
    parameter int IDX        = 0
)
(
    input  logic                     clk,
    input  logic                     adv,
    input  logic [PC_W-1:0]          pc,
    output logic [2*PC_W-1:0]        xx,
    output logic [2*PC_W-1:0]        yy,
    output logic signed [2*PC_W:0]   xy
);

    localparam int COS_V = trig_q15(NUM_ORIENT, IDX, 1'b0);
    localparam int SIN_V = trig_q15(NUM_ORIENT, IDX, 1'b1);
    localparam bit COS_NEG = (COS_V < 0);
    localparam logic [TRIG_W-1:0] COS_MAG = TRIG_W'(COS_NEG ? -COS_V : COS_V);
    localparam logic [TRIG_W-1:0] SIN_MAG = TRIG_W'(SIN_V);
    localparam int PW = PC_W + TRIG_W + 1;
    localparam logic [PW-1:0] HALF_LSB = PW'(1) << (TRIG_FRAC - 1);

    logic [PW-1:0]       xp;
    logic [PW-1:0]       yp;
    logic [PC_W-1:0]     xm_reg;
    logic [PC_W-1:0]     ym_reg;
    logic [2*PC_W-1:0]   pxy;
    logic [2*PC_W-1:0]   xx_reg;
    logic [2*PC_W-1:0]   yy_reg;
    logic signed [2*PC_W:0] xy_reg;

    // Scale by the trig constants and round half away from zero on the magnitude.
    assign xp = PW'(pc) * PW'(COS_MAG) + HALF_LSB;
    assign yp = PW'(pc) * PW'(SIN_MAG) + HALF_LSB;

    // Cross product magnitude; only the cosine can be negative.
    assign pxy = (2 * PC_W)'(xm_reg) * (2 * PC_W)'(ym_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            xm_reg <= xp[TRIG_FRAC +: PC_W];
            ym_reg <= yp[TRIG_FRAC +: PC_W];
            xx_reg <= (2 * PC_W)'(xm_reg) * (2 * PC_W)'(xm_reg);
            yy_reg <= (2 * PC_W)'(ym_reg) * (2 * PC_W)'(ym_reg);
            xy_reg <= COS_NEG ? -signed'({1'b0, pxy}) : signed'({1'b0, pxy});
        end
    end

    assign xx = xx_reg;
    assign yy = yy_reg;
    assign xy = xy_reg;

endmodule

// File: design/pcm_merge.sv
// Merging stage: sums the lane products, forms the covariance terms and the radicand.
module pcm_merge
    import pcm_pkg::*;
#(
    parameter int NUM_ORIENT = 6
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  pipe_ctl_t              ctl,
    input  logic [2*PC_W-1:0]      xx [NUM_ORIENT],
    input  logic [2*PC_W-1:0]      yy [NUM_ORIENT],
    input  logic signed [2*PC_W:0] xy [NUM_ORIENT],
    output logic [SQ_W-1:0]        radicand,
    output logic [SUM_W-1:0]       cov_sum,
    output logic                   vld
);

    localparam int SW    = 2 * PC_W + $clog2(NUM_ORIENT);
    localparam int NW    = SW + 2;
    localparam int QW    = NW - PC_FRAC;
    localparam int DEPTH = 6;
    localparam logic [NW-1:0] HALF_DIV = NW'(NUM_ORIENT) << (PC_FRAC - 1);
    localparam logic [QW-1:0] RECIP    = QW'((64'd1 << QW) / NUM_ORIENT);
    localparam logic [QW-1:0] N_Q      = QW'(NUM_ORIENT);

    logic [SW-1:0]          sxx_sum;
    logic [SW-1:0]          syy_sum;
    logic signed [SW:0]     sxy_sum;
    logic [SW-1:0]          sxx_reg;
    logic [SW-1:0]          syy_reg;
    logic signed [SW:0]     sxy_reg;

    logic [SW:0]            sxy_abs;
    logic [NW-1:0]          nx;
    logic [NW-1:0]          ny;
    logic [NW-1:0]          nxy;
    logic [QW-1:0]          qx_reg;
    logic [QW-1:0]          qy_reg;
    logic [QW-1:0]          qxy_reg;
    logic                   neg2_reg;

    logic [2*QW-1:0]        px;
    logic [2*QW-1:0]        py;
    logic [2*QW-1:0]        pxy;
    logic [QW-1:0]          tx_reg;
    logic [QW-1:0]          ty_reg;
    logic [QW-1:0]          txy_reg;
    logic [QW-1:0]          qx3_reg;
    logic [QW-1:0]          qy3_reg;
    logic [QW-1:0]          qxy3_reg;
    logic                   neg3_reg;

    logic [QW-1:0]          rx;
    logic [QW-1:0]          ry;
    logic [QW-1:0]          rxy;
    logic [QW-1:0]          cx;
    logic [QW-1:0]          cy;
    logic [QW-1:0]          cxy;
    logic [COV_W-1:0]       covx_reg;
    logic [COV_W-1:0]       covy_reg;
    logic signed [COV_W:0]  covxy_reg;

    logic signed [COV_W:0]      diff;
    logic signed [2*COV_W+1:0]  dsq;
    logic signed [2*COV_W+1:0]  csq;
    logic [SQ_W-1:0]        dsq_reg;
    logic [SQ_W-1:0]        csq_reg;
    logic [SUM_W-1:0]       sum5_reg;

    logic [SQ_W-1:0]        sq_reg;
    logic [SUM_W-1:0]       sum6_reg;
    logic [DEPTH-1:0]       vld_reg;

    // Accumulate the lane products.
    always_comb
    begin
        sxx_sum = '0;
        syy_sum = '0;
        sxy_sum = '0;
        for (int i = 0; i < NUM_ORIENT; i++)
        begin
            sxx_sum = sxx_sum + SW'(xx[i]);
            syy_sum = syy_sum + SW'(yy[i]);
            sxy_sum = sxy_sum + (SW + 1)'(xy[i]);
        end
    end

    // Add half the divisor and drop the power-of-two part of N*2^F.
    assign sxy_abs = sxy_reg[SW] ? (SW + 1)'(-sxy_reg) : (SW + 1)'(sxy_reg);
    assign nx      = {sxx_reg, 1'b0} + HALF_DIV;
    assign ny      = {syy_reg, 1'b0} + HALF_DIV;
    assign nxy     = {sxy_abs[SW-1:0], 2'b00} + HALF_DIV;

    // Divide by N: reciprocal estimate, then one correction step.
    assign px  = (2 * QW)'(qx_reg)  * (2 * QW)'(RECIP);
    assign py  = (2 * QW)'(qy_reg)  * (2 * QW)'(RECIP);
    assign pxy = (2 * QW)'(qxy_reg) * (2 * QW)'(RECIP);

    assign rx  = qx3_reg  - QW'(tx_reg  * N_Q);
    assign ry  = qy3_reg  - QW'(ty_reg  * N_Q);
    assign rxy = qxy3_reg - QW'(txy_reg * N_Q);
    assign cx  = (rx  >= N_Q) ? tx_reg  + QW'(1) : tx_reg;
    assign cy  = (ry  >= N_Q) ? ty_reg  + QW'(1) : ty_reg;
    assign cxy = (rxy >= N_Q) ? txy_reg + QW'(1) : txy_reg;

    // Squares for the root term.
    assign diff = signed'({1'b0, covx_reg}) - signed'({1'b0, covy_reg});
    assign dsq  = diff * diff;
    assign csq  = covxy_reg * covxy_reg;

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (ctl.adv)
        begin
            sxx_reg   <= sxx_sum;
            syy_reg   <= syy_sum;
            sxy_reg   <= sxy_sum;

            qx_reg    <= nx[PC_FRAC +: QW];
            qy_reg    <= ny[PC_FRAC +: QW];
            qxy_reg   <= nxy[PC_FRAC +: QW];
            neg2_reg  <= sxy_reg[SW];

            tx_reg    <= px[QW +: QW];
            ty_reg    <= py[QW +: QW];
            txy_reg   <= pxy[QW +: QW];
            qx3_reg   <= qx_reg;
            qy3_reg   <= qy_reg;
            qxy3_reg  <= qxy_reg;
            neg3_reg  <= neg2_reg;

            covx_reg  <= COV_W'(cx);
            covy_reg  <= COV_W'(cy);
            covxy_reg <= neg3_reg ? -signed'({1'b0, COV_W'(cxy)})
                                  : signed'({1'b0, COV_W'(cxy)});

            dsq_reg   <= dsq[SQ_W-1:0];
            csq_reg   <= csq[SQ_W-1:0];
            sum5_reg  <= SUM_W'(covx_reg) + SUM_W'(covy_reg);

            sq_reg    <= dsq_reg + csq_reg;
            sum6_reg  <= sum5_reg;
        end
    end

    // Valid flags follow the datapath.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (ctl.adv)
        begin
            vld_reg <= {vld_reg[DEPTH-2:0], ctl.vld};
        end
    end

    assign radicand = sq_reg;
    assign cov_sum  = sum6_reg;
    assign vld      = vld_reg[DEPTH-1];

endmodule

// File: design/pcm_sqrt.sv
// Pipelined integer square root, one result bit per stage, rounded to nearest.
module pcm_sqrt
    import pcm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  pipe_ctl_t          ctl,
    input  logic [SQ_W-1:0]    radicand,
    input  logic [SUM_W-1:0]   sum_in,
    output logic [ROOT_W-1:0]  root,
    output logic [SUM_W-1:0]   sum_out,
    output logic               vld
);

    localparam int RW = SQ_W + 1;

    logic [SQ_W-1:0]   rem_reg  [ROOT_W];
    logic [RW-1:0]     acc_reg  [ROOT_W];
    logic [SUM_W-1:0]  sum_reg  [ROOT_W];
    logic [SQ_W-1:0]   rem_next [ROOT_W];
    logic [RW-1:0]     acc_next [ROOT_W];
    logic [ROOT_W-1:0] vld_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [SUM_W-1:0]  sum_out_reg;
    logic              vld_out_reg;
    logic              round_up;

    // One digit-pair step per stage, highest pair first.
    for (genvar k = 0; k < ROOT_W; k++)
    begin : g_step
        localparam logic [RW-1:0] BIT = RW'(1) << (2 * (ROOT_W - 1 - k));
        logic [SQ_W-1:0] rem_prev;
        logic [RW-1:0]   acc_prev;
        logic [RW-1:0]   trial;
        logic            take;

        if (k == 0)
        begin : g_first
            assign rem_prev = radicand;
            assign acc_prev = '0;
        end
        else
        begin : g_rest
            assign rem_prev = rem_reg[k-1];
            assign acc_prev = acc_reg[k-1];
        end

        assign trial       = acc_prev + BIT;
        assign take        = ({1'b0, rem_prev} >= trial);
        assign rem_next[k] = take ? rem_prev - trial[SQ_W-1:0] : rem_prev;
        assign acc_next[k] = take ? (acc_prev >> 1) + BIT : (acc_prev >> 1);
    end

    // Round up when the remainder exceeds the floor root.
    assign round_up = ({1'b0, rem_reg[ROOT_W-1]} > acc_reg[ROOT_W-1]);

    // Stage registers.
    always_ff @(posedge clk)
    begin
        if (ctl.adv)
        begin
            sum_reg[0] <= sum_in;
            for (int k = 1; k < ROOT_W; k++)
            begin
                sum_reg[k] <= sum_reg[k-1];
            end
            for (int k = 0; k < ROOT_W; k++)
            begin
                rem_reg[k] <= rem_next[k];
                acc_reg[k] <= acc_next[k];
            end
            root_reg    <= round_up ? ROOT_W'(acc_reg[ROOT_W-1] + RW'(1))
                                    : ROOT_W'(acc_reg[ROOT_W-1]);
            sum_out_reg <= sum_reg[ROOT_W-1];
        end
    end

    // Valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            vld_out_reg <= 1'b0;
        end
        else if (ctl.adv)
        begin
            vld_reg     <= {vld_reg[ROOT_W-2:0], ctl.vld};
            vld_out_reg <= vld_reg[ROOT_W-1];
        end
    end

    assign root    = root_reg;
    assign sum_out = sum_out_reg;
    assign vld     = vld_out_reg;

endmodule

// File: design/phase_congruency_moment_pixel.sv
// Pipeline: an accepted request passes 2 lane, 6 merge, 19 square root, 1 moment
// and 1 output register stages before its result appears.
// Throughput: one request per cycle; the whole pipeline holds only when the output
// register is full, not taken, and the moment stage behind it holds a result.
// Reset clears all valid flags and sets moment_epsilon to 7; no clearing pass.
// Top level of the phase congruency moment block: lanes, merge, root and output stages.
module phase_congruency_moment_pixel
    import pcm_pkg::*;
#(
    parameter int NUM_ORIENT = 6
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [PC_W-1:0]       cfg_wr_data,   // moment_epsilon
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [N_IN*PC_W-1:0]  s_tdata,       // pc_orient_0 .. pc_orient_5, 16 bits each
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [2*OUT_W-1:0]    m_tdata        // edge_strength, corner_strength
);

    logic [PC_W-1:0]       eps_reg;
    logic                  adv;
    logic                  out_load;
    logic [1:0]            lane_vld_reg;
    pipe_ctl_t             merge_ctl;
    pipe_ctl_t             sqrt_ctl;

    logic [2*PC_W-1:0]      lane_xx [NUM_ORIENT];
    logic [2*PC_W-1:0]      lane_yy [NUM_ORIENT];
    logic signed [2*PC_W:0] lane_xy [NUM_ORIENT];

    logic [SQ_W-1:0]       radicand;
    logic [SUM_W-1:0]      cov_sum;
    logic                  merge_vld;
    logic [ROOT_W-1:0]     root;
    logic [SUM_W-1:0]      root_sum;
    logic                  root_vld;

    logic [MOM_W-1:0]      mom_mx;
    logic signed [MOM_W:0] mom_mn;
    logic [MOM_W-1:0]      mom_mx_reg;
    logic signed [MOM_W:0] mom_mn_reg;
    logic                  mom_vld_reg;

    logic                  out_vld_reg;
    logic [OUT_W-1:0]      edge_reg;
    logic [OUT_W-1:0]      corner_reg;

    // Twice a moment to a byte: round(255*m / 2^(F+1)), saturated, non-positive gives zero.
    function automatic logic [OUT_W-1:0] to_byte(input logic signed [MOM_W:0] m);
        logic [MOM_W+OUT_W:0] mag;
        logic [MOM_W+OUT_W:0] prod;
        logic [MOM_W+OUT_W:0] t;
        logic [OUT_W-1:0]     res;
        mag  = (MOM_W + OUT_W + 1)'(m[MOM_W-1:0]);
        prod = (mag << OUT_W) - mag + ((MOM_W + OUT_W + 1)'(1) << PC_FRAC);
        t    = prod >> (PC_FRAC + 1);
        if (m <= 0)
        begin
            res = '0;
        end
        else if (t > (MOM_W + OUT_W + 1)'(BYTE_MAX))
        begin
            res = BYTE_MAX;
        end
        else
        begin
            res = t[OUT_W-1:0];
        end
        return res;
    endfunction

    // Pipeline flow: the output register loads when empty or taken; the rest
    // moves whenever the output loads or the moment stage is empty.
    assign out_load = !out_vld_reg || m_tready;
    assign adv      = out_load || !mom_vld_reg;
    assign s_tready = adv;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eps_reg <= EPS_RESET;
        end
        else if (cfg_wr_en)
        begin
            eps_reg <= cfg_wr_data;
        end
    end

    // One lane per orientation; orientations past the inputs see zero.
    for (genvar g = 0; g < NUM_ORIENT; g++)
    begin : g_lane
        logic [PC_W-1:0] pc_in;

        if (g < N_IN)
        begin : g_used
            assign pc_in = s_tdata[g*PC_W +: PC_W];
        end
        else
        begin : g_zero
            assign pc_in = '0;
        end

        pcm_lane #(
            .NUM_ORIENT (NUM_ORIENT),
            .IDX        (g)
        ) u_lane (
            .clk (clk),
            .adv (adv),
            .pc  (pc_in),
            .xx  (lane_xx[g]),
            .yy  (lane_yy[g]),
            .xy  (lane_xy[g])
        );
    end

    // Valid flags for the lane stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lane_vld_reg <= '0;
        end
        else if (adv)
        begin
            lane_vld_reg <= {lane_vld_reg[0], s_tvalid};
        end
    end

    assign merge_ctl = '{adv: adv, vld: lane_vld_reg[1]};
    assign sqrt_ctl  = '{adv: adv, vld: merge_vld};

    pcm_merge #(
        .NUM_ORIENT (NUM_ORIENT)
    ) u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (merge_ctl),
        .xx       (lane_xx),
        .yy       (lane_yy),
        .xy       (lane_xy),
        .radicand (radicand),
        .cov_sum  (cov_sum),
        .vld      (merge_vld)
    );

    pcm_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (sqrt_ctl),
        .radicand (radicand),
        .sum_in   (cov_sum),
        .root     (root),
        .sum_out  (root_sum),
        .vld      (root_vld)
    );

    // Twice the maximum and minimum moments.
    assign mom_mx = MOM_W'(root_sum) + MOM_W'(root) + MOM_W'(eps_reg);
    assign mom_mn = signed'((MOM_W + 1)'(root_sum)) - signed'((MOM_W + 1)'(root))
                  - signed'((MOM_W + 1)'(eps_reg));

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mom_mx_reg <= mom_mx;
            mom_mn_reg <= mom_mn;
        end
        if (out_load)
        begin
            edge_reg   <= to_byte(signed'({1'b0, mom_mx_reg}));
            corner_reg <= to_byte(mom_mn_reg);
        end
    end

    // Valid flags for the moment and output stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mom_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                mom_vld_reg <= root_vld;
            end
            if (out_load)
            begin
                out_vld_reg <= mom_vld_reg;
            end
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {corner_reg, edge_reg};

`ifndef SYNTH
    // The minimum moment never exceeds the maximum moment.
    a_mom_order: assert property (@(posedge clk) disable iff (!rst_n)
        mom_vld_reg |-> (mom_mn_reg <= signed'({1'b0, mom_mx_reg})))
        else $error("minimum moment above maximum moment");

    // Corner strength never exceeds edge strength on a delivered result.
    a_byte_order: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[2*OUT_W-1:OUT_W] <= m_tdata[OUT_W-1:0]))
        else $error("corner strength above edge strength");

    // The input side only holds off while a result waits at the output.
    a_hold_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !m_tready && mom_vld_reg))
        else $error("input held without a waiting result");
`endif

endmodule
